/* rtl/core/dper_pkg.sv */
// Shared types and constants for the dual presence event reporter.
`timescale 1ns / 1ps

package dper_pkg;

  // Distance code that a sensor sends when it has no reading.
  localparam logic [15:0] NO_DATA = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_NEAR_MM         = 3'd0;
  localparam logic [2:0] REG_FAR_MM          = 3'd1;
  localparam logic [2:0] REG_PAYLOAD_MODE    = 3'd2;
  localparam logic [2:0] REG_GUARD_TICKS     = 3'd3;
  localparam logic [2:0] REG_HEARTBEAT_TICKS = 3'd4;
  localparam logic [2:0] REG_DAILY_BUDGET    = 3'd5;
  localparam logic [2:0] REG_DAY_TICKS       = 3'd6;

  // Configuration reset values.
  localparam logic [15:0] NEAR_MM_RESET         = 16'd300;
  localparam logic [15:0] FAR_MM_RESET          = 16'd500;
  localparam logic [23:0] GUARD_TICKS_RESET     = 24'd1;
  localparam logic [23:0] HEARTBEAT_TICKS_RESET = 24'd0;
  localparam logic [15:0] DAILY_BUDGET_RESET    = 16'd0;
  localparam logic [23:0] DAY_TICKS_RESET       = 24'd86400;

  // Payload modes; the fourth code behaves as flags only.
  typedef enum logic [1:0] {
    MODE_RAW       = 2'd0,
    MODE_FLAGS     = 2'd1,
    MODE_BOTH      = 2'd2,
    MODE_FLAGS_ALT = 2'd3
  } mode_t;

  // Payload lengths in bytes.
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_FLAGS = 3'd1;
  localparam logic [2:0] LEN_RAW   = 3'd4;
  localparam logic [2:0] LEN_BOTH  = 3'd5;

  // Last sent flags value meaning no report has been accepted yet.
  localparam logic [7:0] FLAGS_NONE = 8'hFF;

  // Saturation limit of the per-window report counter.
  localparam logic [15:0] SENT_MAX = 16'hFFFF;

  // One result item.
  typedef struct packed {
    logic        send;
    logic        dropped;
    logic [1:0]  presence_flags;
    logic [15:0] report_a;
    logic [15:0] report_b;
    logic [2:0]  payload_bytes;
  } result_t;

endpackage

/* rtl/core/dual_presence_event_reporter.sv */
// Top level of the dual presence event reporter.
`timescale 1ns / 1ps

// Takes one sample tick per input transfer and returns exactly one result per
// tick. A tick is accepted in every cycle unless in_ready is low: the
// hysteresis flags, the guard, heartbeat and budget checks are evaluated
// combinationally from the input and the state registers, and the result
// lands in an output register backed by a one-entry skid register, so
// in_ready only drops when both hold results that the sink has not taken.
// Tick counts are kept as elapsed counts since the last report and since the
// window start, 32 bits wide and wrapping. Configuration writes take effect
// at once and must only be made while no tick is in flight.
module dual_presence_event_reporter (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] dist_a,
  input  logic [15:0] dist_b,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        send,
  output logic        dropped,
  output logic [1:0]  presence_flags,
  output logic [15:0] report_a,
  output logic [15:0] report_b,
  output logic [2:0]  payload_bytes
);

  import dper_pkg::*;

  // Configuration registers
  logic [15:0] near_mm;
  logic [15:0] far_mm;
  mode_t       payload_mode;
  logic [23:0] guard_ticks;
  logic [23:0] heartbeat_ticks;
  logic [15:0] daily_budget;
  logic [23:0] day_ticks;

  // Tracking state
  logic        near_a;
  logic        near_b;
  logic [7:0]  last_sent_flags;
  logic [31:0] since_send;
  logic [31:0] since_window;
  logic [15:0] sent_in_window;

  // Output register and skid register
  logic        o_valid;
  result_t     o_data;
  logic        s_valid;
  result_t     s_data;

  // Evaluation signals
  logic        accept;
  logic        near_a_next;
  logic        near_b_next;
  logic [1:0]  flags;
  logic [31:0] since_window_inc;
  logic        window_restart;
  logic [15:0] sent_base;
  logic [31:0] since_send_inc;
  logic        changed;
  logic        guard_ok;
  logic        heartbeat;
  logic        want;
  logic        budget_ok;
  logic        send_now;
  result_t     res;

  // Hysteresis update of one sensor flag.
  function automatic logic hysteresis(input logic prev, input logic [15:0] mm,
                                      input logic [15:0] near_lim,
                                      input logic [15:0] far_lim);
    logic r;
    r = prev;
    if (mm != NO_DATA) begin
      if (!prev && (mm < near_lim)) begin
        r = 1'b1;
      end else if (prev && (mm > far_lim)) begin
        r = 1'b0;
      end
    end
    return r;
  endfunction

  assign in_ready = !s_valid;
  assign accept   = in_valid && in_ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      near_mm         <= NEAR_MM_RESET;
      far_mm          <= FAR_MM_RESET;
      payload_mode    <= MODE_FLAGS;
      guard_ticks     <= GUARD_TICKS_RESET;
      heartbeat_ticks <= HEARTBEAT_TICKS_RESET;
      daily_budget    <= DAILY_BUDGET_RESET;
      day_ticks       <= DAY_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEAR_MM:         near_mm         <= cfg_data[15:0];
        REG_FAR_MM:          far_mm          <= cfg_data[15:0];
        REG_PAYLOAD_MODE:    payload_mode    <= mode_t'(cfg_data[1:0]);
        REG_GUARD_TICKS:     guard_ticks     <= cfg_data;
        REG_HEARTBEAT_TICKS: heartbeat_ticks <= cfg_data;
        REG_DAILY_BUDGET:    daily_budget    <= cfg_data[15:0];
        REG_DAY_TICKS:       day_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flag update and report decision for the offered tick.
  always_comb begin
    near_a_next      = hysteresis(near_a, dist_a, near_mm, far_mm);
    near_b_next      = hysteresis(near_b, dist_b, near_mm, far_mm);
    flags            = {near_b_next, near_a_next};

    since_window_inc = since_window + 32'd1;
    window_restart   = since_window_inc >= {8'd0, day_ticks};
    sent_base        = window_restart ? 16'd0 : sent_in_window;

    since_send_inc   = since_send + 32'd1;
    changed          = {6'd0, flags} != last_sent_flags;
    guard_ok         = since_send_inc >= {8'd0, guard_ticks};
    heartbeat        = (heartbeat_ticks != 24'd0) &&
                       (since_send_inc >= {8'd0, heartbeat_ticks});
    want             = (changed && guard_ok) || heartbeat;
    budget_ok        = (daily_budget == 16'd0) || (sent_base < daily_budget);
    send_now         = want && budget_ok;

    if (payload_mode == MODE_RAW) begin
      res.send           = 1'b1;
      res.dropped        = 1'b0;
      res.presence_flags = 2'd0;
      res.report_a       = dist_a;
      res.report_b       = dist_b;
      res.payload_bytes  = LEN_RAW;
    end else begin
      res.send           = send_now;
      res.dropped        = want && !budget_ok;
      res.presence_flags = flags;
      if (send_now && (payload_mode == MODE_BOTH)) begin
        res.report_a      = dist_a;
        res.report_b      = dist_b;
        res.payload_bytes = LEN_BOTH;
      end else begin
        res.report_a      = 16'd0;
        res.report_b      = 16'd0;
        res.payload_bytes = send_now ? LEN_FLAGS : LEN_NONE;
      end
    end
  end

  // State update on each accepted tick; raw mode leaves the state alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      near_a          <= 1'b0;
      near_b          <= 1'b0;
      last_sent_flags <= FLAGS_NONE;
      since_send      <= 32'd0;
      since_window    <= 32'd0;
      sent_in_window  <= 16'd0;
    end else if (accept && (payload_mode != MODE_RAW)) begin
      near_a       <= near_a_next;
      near_b       <= near_b_next;
      since_window <= window_restart ? 32'd0 : since_window_inc;
      since_send   <= want ? 32'd0 : since_send_inc;
      if (want) begin
        last_sent_flags <= {6'd0, flags};
      end
      if (send_now && (sent_base != SENT_MAX)) begin
        sent_in_window <= sent_base + 16'd1;
      end else begin
        sent_in_window <= sent_base;
      end
    end
  end

  // Output register with skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || out_ready) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= accept;
      end
    end else if (accept) begin
      s_valid <= 1'b1;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (!o_valid || out_ready) begin
      o_data <= s_valid ? s_data : res;
    end else if (accept) begin
      s_data <= res;
    end
  end

  assign out_valid      = o_valid;
  assign send           = o_data.send;
  assign dropped        = o_data.dropped;
  assign presence_flags = o_data.presence_flags;
  assign report_a       = o_data.report_a;
  assign report_b       = o_data.report_b;
  assign payload_bytes  = o_data.payload_bytes;

endmodule

/* rtl/core/dper_checker.sv */
// Port-level assertions for the dual presence event reporter and their bind.
`timescale 1ns / 1ps

module dper_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic [2:0]  cfg_index,
  input logic [23:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] dist_a,
  input logic [15:0] dist_b,
  input logic        out_valid,
  input logic        out_ready,
  input logic        send,
  input logic        dropped,
  input logic [1:0]  presence_flags,
  input logic [15:0] report_a,
  input logic [15:0] report_b,
  input logic [2:0]  payload_bytes
);

  import dper_pkg::*;

  // A stalled result keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(send) && $stable(dropped) &&
      $stable(presence_flags) && $stable(report_a) && $stable(report_b) &&
      $stable(payload_bytes))
    else $error("result changed while stalled");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A report carries one of the legal lengths, and no report has length zero.
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (send ? (payload_bytes == LEN_FLAGS || payload_bytes == LEN_RAW ||
                           payload_bytes == LEN_BOTH)
                        : (payload_bytes == LEN_NONE)))
    else $error("payload length does not match send");

  // A dropped report is never also sent.
  a_drop_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> !send && report_a == 16'd0 && report_b == 16'd0)
    else $error("dropped report was sent");

  // Raw results carry no presence flags.
  a_raw_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_bytes == LEN_RAW |-> presence_flags == 2'd0 && !dropped)
    else $error("raw result carries presence state");

endmodule

bind dual_presence_event_reporter dper_checker u_dper_checker (.*);
